### hdl/dirty_page_framebuffer_flush_macros.svh
// Assertion macros shared by the framebuffer flush RTL.
// DPF_ASSERT_IMPL: same-cycle implication. DPF_ASSERT_NEXT: next-cycle implication.
`ifndef DIRTY_PAGE_FRAMEBUFFER_FLUSH_MACROS_SVH
`define DIRTY_PAGE_FRAMEBUFFER_FLUSH_MACROS_SVH
`ifndef SYNTH
`define DPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define DPF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/dpf_pkg.sv
`default_nettype none
package dpf_pkg;

  localparam int WIDTH  = 128;
  localparam int PAGES  = 8;
  localparam int GROUPS = (WIDTH + 7) / 8;
  localparam int ROWS   = PAGES * GROUPS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [2:0] CMD_PIXEL    = 3'd0;
  localparam logic [2:0] CMD_CLEAR    = 3'd1;
  localparam logic [2:0] CMD_ACTIVITY = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_SERVICE  = 3'd4;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_ON   = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  localparam logic [16:0]      IDLE_MAX      = 17'h1FFFF;
  localparam logic [15:0]      TIMEOUT_RESET = 16'd30000;
  localparam logic [PAGES-1:0] ALL_PAGES     = {PAGES{1'b1}};

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clr;
    logic [ROW_AW-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  page;
    logic [3:0]  col_group;
    logic [63:0] data;
    logic        last;
    logic        any_dirty;
    logic        is_blanked;
  } result_t;

  function automatic logic [ROW_AW-1:0] row_addr(input logic [2:0] page,
                                                 input logic [4:0] grp);
    return ROW_AW'(int'(page) * GROUPS + int'(grp));
  endfunction

endpackage
`default_nettype wire

### hdl/dpf_frame_mem.sv
`default_nettype none
module dpf_frame_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dpf_pkg::mem_req_t req_i,
  output logic [63:0]            rdata_o
);
  import dpf_pkg::*;

  logic [63:0]     mem [ROWS];
  logic [63:0]     raw_q;
  logic [ROWS-1:0] row_valid_q;
  logic            rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      raw_q <= mem[req_i.addr];
    end
  end

  // A row never written since reset or clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_valid_q <= '0;
      end else if (req_i.wr) begin
        row_valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rd_valid_q <= row_valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? raw_q : 64'd0;

endmodule
`default_nettype wire

### hdl/dpf_ctrl.sv
`default_nettype none
`include "dirty_page_framebuffer_flush_macros.svh"
module dpf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [2:0]         in_cmd_i,
  input  wire logic [7:0]         in_x_i,
  input  wire logic [6:0]         in_y_i,
  input  wire logic               in_on_i,
  input  wire logic [15:0]        timeout_i,
  input  wire logic               out_free_i,
  output logic                    in_stall_o,
  output dpf_pkg::mem_req_t       mreq_o,
  input  wire logic [63:0]        rdata_i,
  output logic                    push_o,
  output dpf_pkg::result_t        res_o
);
  import dpf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PWR  = 2'd1;
  localparam logic [1:0] ST_FRD  = 2'd2;
  localparam logic [1:0] ST_FWR  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PAGES-1:0]  dirty_q, dirty_d;
  logic [2:0]        next_q, next_d;
  logic              blank_q, blank_d;
  logic [16:0]       idle_q, idle_d;
  logic [3:0]        grp_q, grp_d;
  logic [2:0]        fl_page_q, fl_page_d;
  logic [2:0]        pend_lane_q, pend_lane_d;
  logic [2:0]        pend_bit_q, pend_bit_d;
  logic              pend_on_q, pend_on_d;
  logic [2:0]        pend_page_q, pend_page_d;
  logic [ROW_AW-1:0] pend_addr_q, pend_addr_d;

  logic       acc;
  logic       pix_ok;
  logic       found;
  logic [2:0] pick;

  assign in_stall_o = !(state_q == ST_IDLE && out_free_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign pix_ok     = (int'(in_x_i) < WIDTH) && (int'(in_y_i) < 8 * PAGES);

  // Round-robin search: first dirty page at or after next_q, wrapping.
  always_comb begin
    int idx;
    found = 1'b0;
    pick  = 3'd0;
    for (int i = PAGES - 1; i >= 0; i--) begin
      idx = int'(next_q) + i;
      if (idx >= PAGES) begin
        idx = idx - PAGES;
      end
      if (|(dirty_q & (PAGES'(1) << idx))) begin
        found = 1'b1;
        pick  = 3'(idx);
      end
    end
  end

  always_comb begin
    logic [5:0]  sh;
    logic [7:0]  before_b;
    logic [7:0]  after_b;
    logic [7:0]  mask;
    logic [63:0] row;
    state_d     = state_q;
    dirty_d     = dirty_q;
    next_d      = next_q;
    blank_d     = blank_q;
    idle_d      = idle_q;
    grp_d       = grp_q;
    fl_page_d   = fl_page_q;
    pend_lane_d = pend_lane_q;
    pend_bit_d  = pend_bit_q;
    pend_on_d   = pend_on_q;
    pend_page_d = pend_page_q;
    pend_addr_d = pend_addr_q;
    mreq_o      = '0;
    push_o      = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_ACK;
    res_o.last  = 1'b1;
    sh          = {pend_lane_q, 3'b000};
    before_b    = rdata_i[sh +: 8];
    mask        = 8'd1 << pend_bit_q;
    after_b     = pend_on_q ? (before_b | mask) : (before_b & ~mask);
    row         = rdata_i;
    row[sh +: 8] = after_b;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_cmd_i)
            CMD_PIXEL: begin
              if (pix_ok) begin
                mreq_o.rd   = 1'b1;
                mreq_o.addr = row_addr(in_y_i[5:3], in_x_i[7:3]);
                pend_addr_d = row_addr(in_y_i[5:3], in_x_i[7:3]);
                pend_lane_d = in_x_i[2:0];
                pend_bit_d  = in_y_i[2:0];
                pend_on_d   = in_on_i;
                pend_page_d = in_y_i[5:3];
                state_d     = ST_PWR;
              end else begin
                push_o = 1'b1;
              end
            end
            CMD_CLEAR: begin
              mreq_o.clr = 1'b1;
              dirty_d    = ALL_PAGES;
              push_o     = 1'b1;
            end
            CMD_ACTIVITY: begin
              idle_d = '0;
              push_o = 1'b1;
              if (blank_q) begin
                blank_d    = 1'b0;
                dirty_d    = ALL_PAGES;
                res_o.kind = KIND_ON;
              end
            end
            CMD_TICK: begin
              if (idle_q != IDLE_MAX) begin
                idle_d = idle_q + 17'd1;
              end
              push_o = 1'b1;
            end
            CMD_SERVICE: begin
              if (timeout_i != 16'd0 && !blank_q && idle_q > {1'b0, timeout_i}) begin
                blank_d    = 1'b1;
                res_o.kind = KIND_OFF;
                push_o     = 1'b1;
              end else if (!blank_q && found) begin
                dirty_d   = dirty_q & ~(PAGES'(1) << pick);
                next_d    = (int'(pick) == PAGES - 1) ? 3'd0 : pick + 3'd1;
                fl_page_d = pick;
                grp_d     = '0;
                state_d   = ST_FRD;
              end else begin
                push_o = 1'b1;
              end
            end
            default: begin
              push_o = 1'b1;
            end
          endcase
        end
      end
      ST_PWR: begin
        // Hold the read data until the output register can take the ack.
        if (out_free_i) begin
          mreq_o.wr    = 1'b1;
          mreq_o.addr  = pend_addr_q;
          mreq_o.wdata = row;
          if (after_b != before_b) begin
            dirty_d = dirty_q | (PAGES'(1) << pend_page_q);
          end
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FRD: begin
        mreq_o.rd   = 1'b1;
        mreq_o.addr = row_addr(fl_page_q, {1'b0, grp_q});
        state_d     = ST_FWR;
      end
      ST_FWR: begin
        if (out_free_i) begin
          push_o          = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.page      = fl_page_q;
          res_o.col_group = grp_q;
          res_o.data      = rdata_i;
          res_o.last      = (grp_q == 4'(GROUPS - 1));
          if (grp_q == 4'(GROUPS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            grp_d   = grp_q + 4'd1;
            state_d = ST_FRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.any_dirty  = (dirty_d != '0);
    res_o.is_blanked = blank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dirty_q <= ALL_PAGES;
      next_q  <= 3'd0;
      blank_q <= 1'b0;
      idle_q  <= '0;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      next_q  <= next_d;
      blank_q <= blank_d;
      idle_q  <= idle_d;
      grp_q   <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_page_q   <= fl_page_d;
    pend_lane_q <= pend_lane_d;
    pend_bit_q  <= pend_bit_d;
    pend_on_q   <= pend_on_d;
    pend_page_q <= pend_page_d;
    pend_addr_q <= pend_addr_d;
  end

  `DPF_ASSERT_NEXT(a_pix_rmw, clk_i, rst_ni, acc && in_cmd_i == CMD_PIXEL && pix_ok, state_q == ST_PWR)
  `DPF_ASSERT_NEXT(a_wr_gap, clk_i, rst_ni, mreq_o.wr, !mreq_o.wr)
  `DPF_ASSERT_NEXT(a_flush_end, clk_i, rst_ni, push_o && res_o.kind == KIND_DATA && res_o.last, state_q == ST_IDLE)

endmodule
`default_nettype wire

### hdl/dirty_page_framebuffer_flush.sv
// Page-organized monochrome framebuffer with dirty-page flush.
// Input channel (in_valid_i / in_stall_o) takes one command beat: pixel
// write, clear, activity, millisecond tick or service. Output channel
// (out_valid_o / out_stall_i) returns result beats; out_last_o marks the
// final beat of each command. A beat moves when valid is high and stall low.
// Pixel writes are a read-modify-write of one 64-bit frame memory row,
// written back once the output register is free. Clear, activity, tick and
// non-flushing service return one beat. A flushing service returns one data
// beat per 8 columns (memory read, then output load), 16 beats per page.
// The result sits in an output register; the next command is taken while it
// waits, as long as the register frees up that cycle.
// Reset: frame store reads as zero (per-row valid bits clear at once), all
// pages dirty, panel on, idle count zero, timeout 30000 ms. Clear behaves
// the same way for the store. A stalled output holds its beat and the block
// stalls its input until it is taken. The user must write timeout through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
`default_nettype none
`include "dirty_page_framebuffer_flush_macros.svh"
module dirty_page_framebuffer_flush (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  in_cmd_i,
  input  wire logic [7:0]  in_x_i,
  input  wire logic [6:0]  in_y_i,
  input  wire logic        in_on_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [2:0]       out_page_o,
  output logic [3:0]       out_col_group_o,
  output logic [63:0]      out_data_o,
  output logic             out_last_o,
  output logic             out_any_dirty_o,
  output logic             out_is_blanked_o
);
  import dpf_pkg::*;

  logic [15:0] timeout_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res;
  logic        push;
  logic        out_free;
  mem_req_t    mreq;
  logic [63:0] rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  dpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .in_on_i    (in_on_i),
    .timeout_i  (timeout_q),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .mreq_o     (mreq),
    .rdata_i    (rdata),
    .push_o     (push),
    .res_o      (res)
  );

  dpf_frame_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // Load a new beat when the register is free; hold it until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = res_q.kind;
  assign out_page_o       = res_q.page;
  assign out_col_group_o  = res_q.col_group;
  assign out_data_o       = res_q.data;
  assign out_last_o       = res_q.last;
  assign out_any_dirty_o  = res_q.any_dirty;
  assign out_is_blanked_o = res_q.is_blanked;

  `DPF_ASSERT_IMPL(a_mid_flush_stall, clk_i, rst_ni, out_valid_o && !out_last_o, in_stall_o)

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dpf_pkg::*;

  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 27;

  typedef struct packed {
    logic        cfg_row;
    logic [15:0] value;
    logic [2:0]  cmd;
    logic [7:0]  x;
    logic [6:0]  y;
    logic        on;
    logic        typed;
    logic [1:0]  kind;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  in_cmd_i = '0;
  logic [7:0]  in_x_i = '0;
  logic [6:0]  in_y_i = '0;
  logic        in_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [2:0]  out_page_o;
  logic [3:0]  out_col_group_o;
  logic [63:0] out_data_o;
  logic        out_last_o;
  logic        out_any_dirty_o;
  logic        out_is_blanked_o;

  dirty_page_framebuffer_flush u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_on_i          (in_on_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_page_o       (out_page_o),
    .out_col_group_o  (out_col_group_o),
    .out_data_o       (out_data_o),
    .out_last_o       (out_last_o),
    .out_any_dirty_o  (out_any_dirty_o),
    .out_is_blanked_o (out_is_blanked_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the framebuffer state
  logic [7:0]       frame_shadow [PAGES][WIDTH];
  logic [PAGES-1:0] dirty_shadow;
  logic [2:0]       start_shadow;
  logic             blank_shadow;
  logic [16:0]      idle_shadow;
  logic [15:0]      timeout_shadow;

  result_t expected_beats [$];
  result_t got_beat;
  result_t want_beat;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  bit      idling_on = 1'b0;
  bit      hold_request = 1'b0;

  step_t directed_steps [DIRECTED_ROWS] = '{
    '{1'b0, 16'd0, CMD_SERVICE,    8'd0,   7'd0,   1'b0, 1'b0, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd0,   7'd0,   1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd127, 7'd63,  1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd128, 7'd0,   1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd255, 7'd127, 1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd5,   7'd64,  1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd0,   7'd0,   1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd7,   7'd8,   1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_SERVICE,    8'd0,   7'd0,   1'b0, 1'b0, KIND_ACK},
    '{1'b0, 16'd0, CMD_UNUSED_LO,  8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_UNUSED_MID, 8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_UNUSED_HI,  8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_TICK,       8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_ACTIVITY,   8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_CLEAR,      8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b1, 16'd1, CMD_PIXEL,      8'd0,   7'd0,   1'b0, 1'b0, KIND_ACK},
    '{1'b0, 16'd0, CMD_TICK,       8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_TICK,       8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_SERVICE,    8'd0,   7'd0,   1'b0, 1'b1, KIND_OFF},
    '{1'b0, 16'd0, CMD_SERVICE,    8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_PIXEL,      8'd10,  7'd20,  1'b1, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_ACTIVITY,   8'd0,   7'd0,   1'b0, 1'b1, KIND_ON},
    '{1'b1, 16'd0, CMD_PIXEL,      8'd0,   7'd0,   1'b0, 1'b0, KIND_ACK},
    '{1'b0, 16'd0, CMD_TICK,       8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_TICK,       8'd0,   7'd0,   1'b0, 1'b1, KIND_ACK},
    '{1'b0, 16'd0, CMD_SERVICE,    8'd0,   7'd0,   1'b0, 1'b0, KIND_ACK}
  };

  task automatic push_beat(input logic [1:0] kind, input logic [2:0] page,
                           input logic [3:0] grp, input logic [63:0] data,
                           input logic last);
    result_t beat;
    beat = {kind, page, grp, data, last, |dirty_shadow, blank_shadow};
    expected_beats.push_back(beat);
  endtask

  task automatic predict_beats(input logic [2:0] cmd, input logic [7:0] x,
                               input logic [6:0] y, input logic on);
    int          pg;
    int          p;
    int          i;
    int          g;
    int          b;
    int          col;
    bit          found;
    logic [7:0]  old_byte;
    logic [7:0]  new_byte;
    logic [7:0]  mask;
    logic [63:0] word;
    case (cmd)
      CMD_PIXEL: begin
        if (x < WIDTH && y < 8 * PAGES) begin
          pg = int'(y) >> 3;
          mask = 8'd1 << y[2:0];
          old_byte = frame_shadow[pg][x];
          new_byte = on ? (old_byte | mask) : (old_byte & ~mask);
          frame_shadow[pg][x] = new_byte;
          if (new_byte != old_byte) dirty_shadow[pg] = 1'b1;
        end
        push_beat(KIND_ACK, '0, '0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        foreach (frame_shadow[r, c]) frame_shadow[r][c] = '0;
        dirty_shadow = ALL_PAGES;
        push_beat(KIND_ACK, '0, '0, '0, 1'b1);
      end
      CMD_ACTIVITY: begin
        idle_shadow = '0;
        if (blank_shadow) begin
          blank_shadow = 1'b0;
          dirty_shadow = ALL_PAGES;
          push_beat(KIND_ON, '0, '0, '0, 1'b1);
        end else begin
          push_beat(KIND_ACK, '0, '0, '0, 1'b1);
        end
      end
      CMD_TICK: begin
        if (idle_shadow < IDLE_MAX) idle_shadow = idle_shadow + 1'b1;
        push_beat(KIND_ACK, '0, '0, '0, 1'b1);
      end
      CMD_SERVICE: begin
        if (timeout_shadow != 0 && !blank_shadow && idle_shadow > timeout_shadow) begin
          blank_shadow = 1'b1;
          push_beat(KIND_OFF, '0, '0, '0, 1'b1);
        end else if (!blank_shadow && dirty_shadow != '0) begin
          // round-robin search from the page after the last one flushed
          found = 1'b0;
          p = 0;
          for (i = 0; i < PAGES && !found; i++) begin
            p = (int'(start_shadow) + i) % PAGES;
            if (dirty_shadow[p]) found = 1'b1;
          end
          dirty_shadow[p] = 1'b0;
          start_shadow = 3'((p + 1) % PAGES);
          for (g = 0; g < GROUPS; g++) begin
            word = '0;
            for (b = 0; b < 8; b++) begin
              col = g * 8 + b;
              if (col < WIDTH) word[8*b +: 8] = frame_shadow[p][col];
            end
            push_beat(KIND_DATA, 3'(p), 4'(g), word, g == GROUPS - 1);
          end
        end else begin
          push_beat(KIND_ACK, '0, '0, '0, 1'b1);
        end
      end
      default: push_beat(KIND_ACK, '0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic drive_item(input logic [2:0] cmd, input logic [7:0] x,
                            input logic [6:0] y, input logic on);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i   <= cmd;
    in_x_i     <= x;
    in_y_i     <= y;
    in_on_i    <= on;
    do @(posedge clk_i); while (in_stall_o);
    predict_beats(cmd, x, y, on);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_shadow = value;
  endtask

  task automatic random_item();
    int         pick;
    logic [7:0] rx;
    logic [6:0] ry;
    logic       ron;
    pick = $urandom_range(0, 99);
    ron  = 1'($urandom_range(0, 1));
    // mostly on-panel coordinates, some off-panel noise
    if ($urandom_range(0, 7) == 0) begin
      rx = 8'($urandom_range(0, 255));
      ry = 7'($urandom_range(0, 127));
    end else begin
      rx = 8'($urandom_range(0, WIDTH - 1));
      ry = 7'($urandom_range(0, 8 * PAGES - 1));
    end
    if (pick < 48)      drive_item(CMD_PIXEL, rx, ry, ron);
    else if (pick < 63) drive_item(CMD_SERVICE, rx, ry, ron);
    else if (pick < 79) drive_item(CMD_TICK, rx, ry, ron);
    else if (pick < 89) drive_item(CMD_ACTIVITY, rx, ry, ron);
    else if (pick < 93) drive_item(CMD_CLEAR, rx, ry, ron);
    else drive_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rx, ry, ron);
  endtask

  task automatic run_phase(input int count, input logic [15:0] timeout,
                           input bit with_idle, input bit with_hold);
    int i;
    write_timeout(timeout);
    for (i = 0; i < count; i++) begin
      if (i % 16 == 0) idling_on = with_idle && ($urandom_range(0, 3) != 0);
      if (with_hold && i == 8) begin
        // keep offering beats while the receiver holds off
        idling_on = 1'b0;
        hold_request = 1'b1;
      end
      random_item();
    end
  endtask

  task automatic note_mismatch(input string what, input result_t want,
                               input result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $write("%s: expected kind %0d page %0d grp %0d data %h last %b dirty %b blank %b, ",
             what, want.kind, want.page, want.col_group, want.data, want.last,
             want.any_dirty, want.is_blanked);
      $display("got kind %0d page %0d grp %0d data %h last %b dirty %b blank %b",
               got.kind, got.page, got.col_group, got.data, got.last,
               got.any_dirty, got.is_blanked);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat = {out_kind_o, out_page_o, out_col_group_o, out_data_o, out_last_o,
                  out_any_dirty_o, out_is_blanked_o};
      if (expected_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, got_beat);
      end else begin
        want_beat = expected_beats.pop_front();
        if (got_beat !== want_beat) note_mismatch("beat mismatch", want_beat, got_beat);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int i;
    foreach (frame_shadow[r, c]) frame_shadow[r][c] = '0;
    dirty_shadow   = ALL_PAGES;
    start_shadow   = '0;
    blank_shadow   = 1'b0;
    idle_shadow    = '0;
    timeout_shadow = TIMEOUT_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].cfg_row) begin
        write_timeout(directed_steps[k].value);
      end else begin
        drive_item(directed_steps[k].cmd, directed_steps[k].x, directed_steps[k].y,
                   directed_steps[k].on);
        if (directed_steps[k].typed) expected_beats[$].kind = directed_steps[k].kind;
      end
    end

    run_phase(50, 16'($urandom_range(2, 12)), 1'b1, 1'b1);
    run_phase(50, 16'd1, 1'b1, 1'b0);
    run_phase(45, 16'd0, 1'b1, 1'b0);

    // a few ticks against the largest timeout must not blank the panel
    idling_on = 1'b0;
    write_timeout(16'hFFFF);
    drive_item(CMD_ACTIVITY, '0, '0, 1'b0);
    for (i = 0; i < 4; i++) drive_item(CMD_TICK, '0, '0, 1'b0);
    drive_item(CMD_SERVICE, '0, '0, 1'b0);
    drive_item(CMD_ACTIVITY, '0, '0, 1'b0);

    run_phase(38, 16'($urandom_range(2, 40)), 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/dpf_pkg.sv
hdl/dpf_frame_mem.sv
hdl/dpf_ctrl.sv
hdl/dirty_page_framebuffer_flush.sv
tb/tb_top.sv
